// ===== hdl/cwcc_pkg.sv =====
package cwcc_pkg;

  localparam int CAPTURES_PER_WINDOW = 32;
  localparam int AVERAGE_SHIFT = 12;
  localparam int NOISE_WARMUP_WINDOWS = 8;

  localparam int CAP_W = 16;
  localparam int CNT_W = $clog2(CAPTURES_PER_WINDOW + 1);
  localparam int TICK_W = CAP_W + $clog2(CAPTURES_PER_WINDOW + 1);
  localparam int Q_FRAC = 24;
  localparam int DIVD_W = TICK_W + Q_FRAC;
  localparam int NOM_W = 22;
  localparam int SCALE_W = 26;
  localparam int ACC_W = SCALE_W + AVERAGE_SHIFT;
  localparam int CNT32_W = 32;
  localparam int PPM_W = 21;
  localparam int DEV_W = 25;
  localparam int PPM_K_W = 20;
  localparam int PROD_W = DEV_W + PPM_K_W;

  localparam logic [SCALE_W-1:0] Q24_ONE = SCALE_W'(1) << Q_FRAC;
  localparam logic [SCALE_W-1:0] RAW_LIMIT = SCALE_W'(1) << (Q_FRAC + 1);
  localparam logic [PPM_K_W-1:0] PPM_SCALE = PPM_K_W'(1000000);
  localparam logic [CAP_W-1:0] SPAN_LOW_INIT = '1;
  localparam logic [CNT32_W-1:0] CNT32_MAX = '1;

  typedef enum logic [2:0] {
    ST_REF    = 3'd0,
    ST_ACCEPT = 3'd1,
    ST_REJECT = 3'd2,
    ST_OVER   = 3'd3,
    ST_WINDOW = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    CFG_ENABLE   = 2'd0,
    CFG_SPAN_MIN = 2'd1,
    CFG_SPAN_MAX = 2'd2,
    CFG_NOMINAL  = 2'd3
  } cfg_index_t;

  typedef enum logic [3:0] {
    S_IDLE, S_RAW_GO, S_RAW, S_AVG, S_MEAN,
    S_NOISE_GO, S_NOISE, S_SCALE_GO, S_SCALE, S_OUT
  } state_t;

  function automatic logic q24_below(input logic [SCALE_W-1:0] q);
    return q < Q24_ONE;
  endfunction

  function automatic logic [DEV_W-1:0] q24_dev(input logic [SCALE_W-1:0] q);
    logic [SCALE_W-1:0] d;
    d = (q < Q24_ONE) ? (Q24_ONE - q) : (q - Q24_ONE);
    return d[DEV_W-1:0];
  endfunction

  function automatic logic signed [PPM_W-1:0] prod_to_ppm(input logic neg,
                                                         input logic [PROD_W-1:0] p);
    logic [PROD_W:0] s;
    logic [PPM_W-1:0] mag;
    s = neg ? ({1'b0, p} + ((PROD_W + 1)'(1) << Q_FRAC) - (PROD_W + 1)'(1)) : {1'b0, p};
    mag = s[Q_FRAC +: PPM_W];
    return neg ? -$signed(mag) : $signed(mag);
  endfunction

endpackage

// ===== hdl/cwcc_if.sv =====
interface cwcc_in_if import cwcc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CAP_W-1:0] capture_value;
  logic             overcapture;
  modport source(output valid, capture_value, overcapture, input ready);
  modport sink(input valid, capture_value, overcapture, output ready);
endinterface

interface cwcc_out_if import cwcc_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [2:0]                status;
  logic                      ready_res;
  logic [SCALE_W-1:0]        scale;
  logic [CNT32_W-1:0]        window_count;
  logic [CNT32_W-1:0]        reject_count;
  logic [CAP_W-1:0]          last_span_low;
  logic [CAP_W-1:0]          last_span_high;
  logic signed [PPM_W-1:0]   noise_ppm_low;
  logic signed [PPM_W-1:0]   noise_ppm_high;
  logic signed [PPM_W-1:0]   scale_ppm;
  modport source(output valid, status, ready_res, scale, window_count, reject_count,
                 last_span_low, last_span_high, noise_ppm_low, noise_ppm_high,
                 scale_ppm, input ready);
  modport sink(input valid, status, ready_res, scale, window_count, reject_count,
               last_span_low, last_span_high, noise_ppm_low, noise_ppm_high,
               scale_ppm, output ready);
endinterface

// ===== hdl/cwcc_div.sv =====
module cwcc_div import cwcc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DIVD_W-1:0] dividend,
  input  logic [NOM_W-1:0]  divisor,
  output logic              done,
  output logic [DIVD_W-1:0] quotient
);

  localparam int STEP_W = $clog2(DIVD_W + 1);

  logic [DIVD_W-1:0] quo_r, quo_nxt;
  logic [NOM_W-1:0]  rem_r, rem_nxt;
  logic [NOM_W-1:0]  dvs_r;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              done_r, done_nxt;
  logic [NOM_W:0]    trial;

  always_comb begin
    trial = {rem_r, quo_r[DIVD_W-1]};
    quo_nxt = {quo_r[DIVD_W-2:0], 1'b0};
    rem_nxt = trial[NOM_W-1:0];
    if (trial >= {1'b0, dvs_r}) begin
      rem_nxt = NOM_W'(trial - {1'b0, dvs_r});
      quo_nxt[0] = 1'b1;
    end
    step_nxt = step_r - STEP_W'(1);
    done_nxt = (step_r == STEP_W'(1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
      done_r <= 1'b0;
    end else if (start) begin
      step_r <= STEP_W'(DIVD_W);
      done_r <= 1'b0;
    end else if (step_r != '0) begin
      step_r <= step_nxt;
      done_r <= done_nxt;
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (step_r != '0) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done = done_r;
  assign quotient = quo_r;

endmodule

// ===== hdl/cwcc_mul.sv =====
module cwcc_mul import cwcc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DEV_W-1:0]  a,
  output logic              done,
  output logic [PROD_W-1:0] prod
);

  localparam int STEP_W = $clog2(DEV_W + 1);

  logic [DEV_W-1:0]  a_r;
  logic [PROD_W-1:0] acc_r, acc_nxt;
  logic [STEP_W-1:0] step_r;
  logic              done_r;

  always_comb begin
    acc_nxt = {acc_r[PROD_W-2:0], 1'b0} + (a_r[DEV_W-1] ? PROD_W'(PPM_SCALE) : '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
      done_r <= 1'b0;
    end else if (start) begin
      step_r <= STEP_W'(DEV_W);
      done_r <= 1'b0;
    end else if (step_r != '0) begin
      step_r <= step_r - STEP_W'(1);
      done_r <= (step_r == STEP_W'(1));
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= a;
      acc_r <= '0;
    end else if (step_r != '0) begin
      a_r <= {a_r[DEV_W-2:0], 1'b0};
      acc_r <= acc_nxt;
    end
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule

// ===== hdl/crystal_window_clock_calibrator.sv =====
// An ordinary capture goes from idle to the output state, which loads the output register.
// A capture that closes a window waits for its result while a 46-step
// serial divider and a 25-step serial multiplier each run twice, one after the other.
// The second division is skipped once the running mean gives way to the average, and the first
// multiplication before the noise warm-up ends. A result waiting in the output register stalls
// the next capture. Synchronous active-low reset clears all but the datapath registers.
module crystal_window_clock_calibrator import cwcc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  cwcc_in_if.sink          in_if,
  cwcc_out_if.source       out_if,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [NOM_W-1:0] cfg_data
);

  state_t state_r, state_nxt;

  logic               enable_r;
  logic [CAP_W-1:0]   span_min_r, span_max_r;
  logic [NOM_W-1:0]   nom_r;
  logic               ref_held_r;
  logic [CAP_W-1:0]   prev_r;
  logic [TICK_W-1:0]  tick_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [CAP_W-1:0]   wlow_r, whigh_r, dlow_r, dhigh_r;
  logic [ACC_W-1:0]   acc_r;
  logic [SCALE_W-1:0] scale_r, raw_r;
  logic [CNT32_W-1:0] wdone_r, rej_r;
  logic               nvalid_r, ready_r;
  logic signed [PPM_W-1:0] nlow_r, nhigh_r, scale_ppm_r;
  status_t            status_r;

  logic               ovalid_r;
  logic [2:0]         ostatus_r;
  logic               oready_res_r;
  logic [SCALE_W-1:0] oscale_r;
  logic [CNT32_W-1:0] owin_r, orej_r;
  logic [CAP_W-1:0]   olow_r, ohigh_r;
  logic signed [PPM_W-1:0] onlow_r, onhigh_r, oppm_r;

  logic               accept, load_out, in_mean, warm;
  logic [CAP_W-1:0]   span;
  logic               reject, finishing;
  logic [TICK_W-1:0]  tick_add;
  logic [CNT_W-1:0]   cnt_inc;
  logic [CAP_W-1:0]   wlow_upd, whigh_upd;
  logic [ACC_W-1:0]   acc_add, acc_ema;

  logic               div_start, div_done;
  logic [DIVD_W-1:0]  div_dividend, div_q;
  logic [NOM_W-1:0]   div_divisor;
  logic               mul_start, mul_done;
  logic [DEV_W-1:0]   mul_a;
  logic [PROD_W-1:0]  mul_p;
  logic signed [PPM_W-1:0] ppm_res;
  logic [SCALE_W-1:0] raw_sat;

  cwcc_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_dividend),
    .divisor(div_divisor), .done(div_done), .quotient(div_q)
  );

  cwcc_mul u_mul (
    .clk(clk), .rst_n(rst_n), .start(mul_start), .a(mul_a), .done(mul_done), .prod(mul_p)
  );

  always_comb begin
    span = in_if.capture_value - prev_r;
    reject = (span < span_min_r) || (span > span_max_r);
    tick_add = tick_r + TICK_W'(span);
    cnt_inc = cnt_r + CNT_W'(1);
    finishing = (cnt_inc >= CNT_W'(CAPTURES_PER_WINDOW));
    wlow_upd = (span < wlow_r) ? span : wlow_r;
    whigh_upd = (span > whigh_r) ? span : whigh_r;
    in_mean = (wdone_r < (CNT32_W'(1) << AVERAGE_SHIFT));
    acc_add = acc_r + ACC_W'(raw_r);
    acc_ema = acc_r - (acc_r >> AVERAGE_SHIFT) + ACC_W'(raw_r);
    warm = (wdone_r > CNT32_W'(NOISE_WARMUP_WINDOWS));
    raw_sat = ((div_q >> (Q_FRAC + 1)) > DIVD_W'(1) ||
               (div_q > DIVD_W'(RAW_LIMIT))) ? RAW_LIMIT : div_q[SCALE_W-1:0];
    ppm_res = prod_to_ppm((state_r == S_NOISE) ? q24_below(raw_r) : q24_below(scale_r),
                          mul_p);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_if.valid && enable_r) begin
          state_nxt = (!in_if.overcapture && ref_held_r && !reject && finishing) ?
                      S_RAW_GO : S_OUT;
        end
      end
      S_RAW_GO:   state_nxt = S_RAW;
      S_RAW:      if (div_done) state_nxt = S_AVG;
      S_AVG:      state_nxt = in_mean ? S_MEAN : S_NOISE_GO;
      S_MEAN:     if (div_done) state_nxt = S_NOISE_GO;
      S_NOISE_GO: state_nxt = warm ? S_NOISE : S_SCALE_GO;
      S_NOISE:    if (mul_done) state_nxt = S_SCALE_GO;
      S_SCALE_GO: state_nxt = S_SCALE;
      S_SCALE:    if (mul_done) state_nxt = S_OUT;
      S_OUT:      if (!ovalid_r || out_if.ready) state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_if.ready = (state_r == S_IDLE);
    accept = in_if.valid && (state_r == S_IDLE);
    load_out = (state_r == S_OUT) && (!ovalid_r || out_if.ready);
    div_start = (state_r == S_RAW_GO) || ((state_r == S_AVG) && in_mean);
    div_dividend = (state_r == S_RAW_GO) ? {tick_r, Q_FRAC'(0)} : DIVD_W'(acc_add);
    div_divisor = (state_r == S_RAW_GO) ? ((nom_r == '0) ? NOM_W'(1) : nom_r) :
                  (NOM_W'(wdone_r) + NOM_W'(1));
    mul_start = ((state_r == S_NOISE_GO) && warm) || (state_r == S_SCALE_GO);
    mul_a = (state_r == S_NOISE_GO) ? q24_dev(raw_r) : q24_dev(scale_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      enable_r <= 1'b0;
      span_min_r <= '0;
      span_max_r <= '1;
      nom_r <= NOM_W'(1);
      ref_held_r <= 1'b0;
      prev_r <= '0;
      tick_r <= '0;
      cnt_r <= '0;
      wlow_r <= SPAN_LOW_INIT;
      whigh_r <= '0;
      acc_r <= '0;
      scale_r <= Q24_ONE;
      raw_r <= '0;
      wdone_r <= '0;
      rej_r <= '0;
      dlow_r <= '0;
      dhigh_r <= '0;
      nvalid_r <= 1'b0;
      nlow_r <= '0;
      nhigh_r <= '0;
      scale_ppm_r <= '0;
      ready_r <= 1'b0;
      status_r <= ST_REF;
      ovalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_index_t'(cfg_index))
          CFG_ENABLE: begin
            enable_r <= cfg_data[0];
            if (cfg_data[0]) begin
              ref_held_r <= 1'b0;
              tick_r <= '0;
              cnt_r <= '0;
              wlow_r <= SPAN_LOW_INIT;
              whigh_r <= '0;
            end
          end
          CFG_SPAN_MIN: span_min_r <= cfg_data[CAP_W-1:0];
          CFG_SPAN_MAX: span_max_r <= cfg_data[CAP_W-1:0];
          CFG_NOMINAL:  nom_r <= cfg_data;
          default: ;
        endcase
      end
      if (accept && enable_r) begin
        if (in_if.overcapture) begin
          ref_held_r <= 1'b0;
          tick_r <= '0;
          cnt_r <= '0;
          wlow_r <= SPAN_LOW_INIT;
          whigh_r <= '0;
          status_r <= ST_OVER;
        end else if (!ref_held_r) begin
          prev_r <= in_if.capture_value;
          ref_held_r <= 1'b1;
          status_r <= ST_REF;
        end else begin
          prev_r <= in_if.capture_value;
          if (reject) begin
            if (rej_r != CNT32_MAX) rej_r <= rej_r + CNT32_W'(1);
            ref_held_r <= 1'b0;
            tick_r <= '0;
            cnt_r <= '0;
            wlow_r <= SPAN_LOW_INIT;
            whigh_r <= '0;
            status_r <= ST_REJECT;
          end else if (finishing) begin
            tick_r <= tick_add;
            cnt_r <= '0;
            dlow_r <= wlow_upd;
            dhigh_r <= whigh_upd;
            wlow_r <= SPAN_LOW_INIT;
            whigh_r <= '0;
            status_r <= ST_WINDOW;
          end else begin
            tick_r <= tick_add;
            cnt_r <= cnt_inc;
            wlow_r <= wlow_upd;
            whigh_r <= whigh_upd;
            status_r <= ST_ACCEPT;
          end
        end
      end
      if (state_r == S_RAW_GO) tick_r <= '0;
      if ((state_r == S_RAW) && div_done) raw_r <= raw_sat;
      if (state_r == S_AVG) begin
        if (in_mean) begin
          acc_r <= acc_add;
        end else begin
          acc_r <= acc_ema;
          scale_r <= acc_ema[AVERAGE_SHIFT +: SCALE_W];
        end
        if (wdone_r != CNT32_MAX) wdone_r <= wdone_r + CNT32_W'(1);
        ready_r <= 1'b1;
      end
      if ((state_r == S_MEAN) && div_done) scale_r <= div_q[SCALE_W-1:0];
      if ((state_r == S_NOISE) && mul_done) begin
        nvalid_r <= 1'b1;
        if (!nvalid_r || (ppm_res < nlow_r)) nlow_r <= ppm_res;
        if (!nvalid_r || (ppm_res > nhigh_r)) nhigh_r <= ppm_res;
      end
      if ((state_r == S_SCALE) && mul_done) scale_ppm_r <= ppm_res;
      if (load_out) begin
        ovalid_r <= 1'b1;
      end else if (out_if.ready) begin
        ovalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      ostatus_r <= status_r;
      oready_res_r <= ready_r;
      oscale_r <= scale_r;
      owin_r <= wdone_r;
      orej_r <= rej_r;
      olow_r <= dlow_r;
      ohigh_r <= dhigh_r;
      onlow_r <= warm ? nlow_r : '0;
      onhigh_r <= warm ? nhigh_r : '0;
      oppm_r <= scale_ppm_r;
    end
  end

  assign out_if.valid = ovalid_r;
  assign out_if.status = ostatus_r;
  assign out_if.ready_res = oready_res_r;
  assign out_if.scale = oscale_r;
  assign out_if.window_count = owin_r;
  assign out_if.reject_count = orej_r;
  assign out_if.last_span_low = olow_r;
  assign out_if.last_span_high = ohigh_r;
  assign out_if.noise_ppm_low = onlow_r;
  assign out_if.noise_ppm_high = onhigh_r;
  assign out_if.scale_ppm = oppm_r;

endmodule

// ===== hdl/cwcc_checker.sv =====
module cwcc_checker import cwcc_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input logic [2:0]         out_status,
  input logic               out_ready_res,
  input logic [SCALE_W-1:0] out_scale,
  input logic [CNT32_W-1:0] out_window_count
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result request dropped while stalled");

  a_ready_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready_res |-> out_window_count == '0)
    else $error("windows counted without ready flag");

  a_scale_init: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_window_count == '0 |-> out_scale == Q24_ONE && !out_ready_res)
    else $error("scale moved before the first window");

  a_window_ready: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_WINDOW |-> out_ready_res && out_window_count != '0)
    else $error("completed window not reflected in ready flag");

endmodule

bind crystal_window_clock_calibrator cwcc_checker u_cwcc_checker (
  .clk(clk),
  .rst_n(rst_n),
  .out_valid(out_if.valid),
  .out_ready(out_if.ready),
  .out_status(out_if.status),
  .out_ready_res(out_if.ready_res),
  .out_scale(out_if.scale),
  .out_window_count(out_if.window_count)
);
